### rtl/assert_macros.svh
// assertion macros for the rtl files, included by nvrgb_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/nvrgb_pkg.sv
// shared constants, types and register codes of the nv21 to rgb converter
`timescale 1ns / 1ps

package nvrgb_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int QUEUE_DEPTH = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int PIX_IDX_W   = 20;

    typedef struct packed {
        logic fifo_full;
        logic back_idle;
    } t_back_stat;

endpackage

### rtl/nvrgb_fifo.sv
// short block queue between the front and the back
`timescale 1ns / 1ps

module nvrgb_fifo
    import nvrgb_pkg::*;
#(
    parameter int DW    = 16,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DW-1:0]   r_mem [DEPTH];
    logic [PTRW-1:0] r_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr;
    logic [CNTW-1:0] r_count;

    function automatic logic [PTRW-1:0] ptr_inc(logic [PTRW-1:0] p);
        if (p == PTRW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTRW'(1);
    endfunction

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

endmodule

### rtl/nvrgb_front.sv
// front: config registers, byte position tracking, luma writes and block classification
`timescale 1ns / 1ps

module nvrgb_front
    import nvrgb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH),
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int CRW   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1,
    localparam int BW    = 16 + WW + CRW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [IN_TDATA_W-1:0] i_data,
    input  logic                  i_frame_start,
    input  t_back_stat            i_stat,
    output logic                  o_blk_push,
    output logic [BW-1:0]         o_blk_data,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [7:0]            o_wr_data,
    output logic [WW-1:0]         o_width
);

    localparam int PW  = $clog2(DEPTH + DEPTH / 2 + 1);
    localparam int DCW = $clog2(PW + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);

    localparam logic [2:0] ST_SET1 = 3'd0;
    localparam logic [2:0] ST_SET2 = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_RUN  = 3'd4;

    logic [2:0]       r_state;
    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic [PW-1:0]    r_wh;
    logic [PW-1:0]    r_total;
    logic [PW-1:0]    r_pos;
    logic [7:0]       r_held_v;
    logic [CRW-1:0]   r_krow;
    logic [WW-1:0]    r_krem;
    logic [PW-1:0]    r_div_num;
    logic [WW-1:0]    r_div_rem;
    logic [PW-1:0]    r_div_q;
    logic [DCW-1:0]   r_div_cnt;

    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [PW-1:0]    pos;
    logic             in_frame;
    logic             is_luma;
    logic             is_u;
    logic             acc;
    logic [WW:0]      rem_sh;
    logic             div_ge;
    logic [WW:0]      n_rem;
    logic [PW-1:0]    n_q;

    // even, at least 2, at most the even part of the maximum
    function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned maxv);
        int unsigned m;
        int unsigned e;
        m = maxv & 32'hFFFF_FFFE;
        e = 32'({v[CFG_W-1:1], 1'b0});
        if (e < 2) begin
            e = 2;
        end
        if (e > m) begin
            e = m;
        end
        return e;
    endfunction

    assign w_eff   = WW'(eff_dim(r_cfg_w, MAX_WIDTH));
    assign h_eff   = HW'(eff_dim(r_cfg_h, MAX_HEIGHT));
    assign o_width = w_eff;

    assign pos      = i_frame_start ? '0 : r_pos;
    assign in_frame = (pos < r_total);
    assign is_luma  = (pos < r_wh);
    // luma plane size is even, so chroma parity follows the position
    assign is_u     = pos[0];

    always_comb begin
        o_tready = 1'b0;
        if (r_state == ST_RUN) begin
            if (!in_frame) begin
                o_tready = 1'b1;
            end else if (is_luma) begin
                // never overwrite luma a queued block still has to read
                o_tready = i_stat.back_idle;
            end else begin
                o_tready = !is_u || !i_stat.fifo_full;
            end
        end
    end

    assign acc = i_tvalid && o_tready;

    assign o_wr_en    = acc && in_frame && is_luma;
    assign o_wr_addr  = AW'(pos);
    assign o_wr_data  = i_data;
    assign o_blk_push = acc && in_frame && !is_luma && is_u;
    assign o_blk_data = {r_krow, r_krem[WW-1:1], 1'b0, r_held_v, i_data};

    // restoring divider step, resyncs chroma row and column after a size change
    assign rem_sh = {r_div_rem, r_div_num[PW-1]};
    assign div_ge = (rem_sh >= {1'b0, w_eff});
    assign n_rem  = div_ge ? (rem_sh - {1'b0, w_eff}) : rem_sh;
    assign n_q    = {r_div_q[PW-2:0], div_ge};

    always_ff @(posedge i_clk) begin
        r_wh    <= PW'(32'(w_eff) * 32'(h_eff));
        r_total <= r_wh + (r_wh >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            r_div_num <= r_pos - r_wh;
            r_div_rem <= '0;
            r_div_q   <= '0;
        end else if (r_state == ST_DIV) begin
            r_div_num <= r_div_num << 1;
            r_div_rem <= WW'(n_rem);
            r_div_q   <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SET1;
            r_cfg_w   <= CFG_W'(RESET_WIDTH);
            r_cfg_h   <= CFG_W'(RESET_HEIGHT);
            r_pos     <= '0;
            r_held_v  <= '0;
            r_krow    <= '0;
            r_krem    <= '0;
            r_div_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cfg_we) begin
                r_state <= ST_SET1;
            end else begin
                case (r_state)
                    ST_SET1: r_state <= ST_SET2;
                    ST_SET2: r_state <= ST_LOAD;
                    ST_LOAD: begin
                        r_div_cnt <= DCW'(PW);
                        r_state   <= ST_DIV;
                    end
                    ST_DIV: begin
                        r_div_cnt <= r_div_cnt - DCW'(1);
                        if (r_div_cnt == DCW'(1)) begin
                            r_krow  <= CRW'(n_q);
                            r_krem  <= WW'(n_rem);
                            r_state <= ST_RUN;
                        end
                    end
                    ST_RUN: begin
                        if (acc) begin
                            if (!in_frame) begin
                                r_pos <= r_total;
                            end else begin
                                r_pos <= pos + PW'(1);
                                if (is_luma) begin
                                    if (pos == r_wh - PW'(1)) begin
                                        r_krow <= '0;
                                        r_krem <= '0;
                                    end
                                end else begin
                                    if (!is_u) begin
                                        r_held_v <= i_data;
                                    end
                                    if (r_krem == w_eff - WW'(1)) begin
                                        r_krem <= '0;
                                        r_krow <= r_krow + CRW'(1);
                                    end else begin
                                        r_krem <= r_krem + WW'(1);
                                    end
                                end
                            end
                        end
                    end
                    default: r_state <= ST_SET1;
                endcase
            end
        end
    end

endmodule

### rtl/nvrgb_back.sv
// back: luma memory, block address generation and color conversion
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nvrgb_back
    import nvrgb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH),
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int CRW   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1,
    localparam int BW    = 16 + WW + CRW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [BW-1:0]          i_blk_data,
    input  logic                   i_blk_empty,
    output logic                   o_blk_pop,
    input  logic [WW-1:0]          i_width,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [7:0]             i_wr_data,
    output logic                   o_idle,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tlast
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_PREP = 2'd1;
    localparam logic [1:0] B_RD   = 2'd2;
    localparam logic [1:0] B_CALC = 2'd3;

    // q16 coefficients
    localparam logic signed [27:0] COEF_RV = 28'sd89831;
    localparam logic signed [27:0] COEF_GV = 28'sd45744;
    localparam logic signed [27:0] COEF_GU = 28'sd22127;
    localparam logic signed [27:0] COEF_BU = 28'sd113538;

    logic [7:0]              r_mem [DEPTH];
    logic [1:0]              r_state;
    logic [1:0]              r_pix;
    logic [7:0]              r_u;
    logic [7:0]              r_v;
    logic [WW-1:0]           r_ccol;
    logic [CRW-1:0]          r_crow;
    logic [AW-1:0]           r_base;
    logic signed [27:0]      r_prv;
    logic signed [27:0]      r_pg;
    logic signed [27:0]      r_pbu;
    logic [7:0]              r_rd_data;
    logic [AW-1:0]           r_rd_idx;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;
    logic                    r_out_last;

    logic signed [8:0]       du;
    logic signed [8:0]       dv;
    logic [31:0]             base_full;
    logic                    out_free;
    logic                    load;
    logic                    rd_en;
    logic [1:0]              rd_pix;
    logic [AW-1:0]           rd_addr;
    logic signed [27:0]      yq;
    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;
    logic [31:0]             idx_ext;

    // negative to zero, else floor of q16 saturated at 255
    function automatic logic [7:0] clamp_q16(logic signed [27:0] s);
        if (s[27]) begin
            return 8'd0;
        end
        if (|s[26:24]) begin
            return 8'd255;
        end
        return s[23:16];
    endfunction

    assign du = $signed({1'b0, r_u}) - 9'sd128;
    assign dv = $signed({1'b0, r_v}) - 9'sd128;

    assign base_full = ((32'(r_crow) * 32'(i_width)) << 1) + 32'(r_ccol);

    assign out_free  = !r_out_valid || i_tready;
    assign load      = (r_state == B_CALC) && out_free;
    assign o_blk_pop = (r_state == B_IDLE) && !i_blk_empty;
    assign o_idle    = (r_state == B_IDLE);

    // next read is issued in the same cycle a pixel is handed out
    always_comb begin
        rd_en  = 1'b0;
        rd_pix = r_pix;
        if (r_state == B_RD) begin
            rd_en = 1'b1;
        end else if (load && (r_pix != 2'd3)) begin
            rd_en  = 1'b1;
            rd_pix = r_pix + 2'd1;
        end
    end

    assign rd_addr = r_base + (rd_pix[1] ? AW'(i_width) : AW'(0)) + AW'(rd_pix[0]);

    assign yq    = $signed(28'({r_rd_data, 16'h0000}));
    assign red   = clamp_q16(yq + r_prv);
    assign green = clamp_q16(yq + r_pg);
    assign blue  = clamp_q16(yq + r_pbu);

    assign idx_ext = 32'(r_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_idx  <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_blk_pop) begin
            r_u    <= i_blk_data[7:0];
            r_v    <= i_blk_data[15:8];
            r_ccol <= i_blk_data[16 +: WW];
            r_crow <= i_blk_data[16 + WW +: CRW];
        end
        if (r_state == B_PREP) begin
            r_base <= AW'(base_full);
            r_prv  <= COEF_RV * 28'(dv);
            r_pg   <= -(COEF_GV * 28'(dv)) - (COEF_GU * 28'(du));
            r_pbu  <= COEF_BU * 28'(du);
        end
        if (load) begin
            r_out_data <= {4'h0, idx_ext[PIX_IDX_W-1:0], red, green, blue, blue, green, red};
            r_out_last <= (r_pix == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_pix       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_blk_pop) begin
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    r_pix   <= '0;
                    r_state <= B_RD;
                end
                B_RD: r_state <= B_CALC;
                B_CALC: begin
                    if (load) begin
                        r_pix <= r_pix + 2'd1;
                        if (r_pix == 2'd3) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;

    `ASSERT_ALWAYS(a_wr_only_idle, i_clk, i_rst_n, i_wr_en |-> (r_state == B_IDLE), "luma write while a block is in flight")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, o_blk_pop && i_blk_empty, "pop from empty block queue")
    `ASSERT_ALWAYS(a_calc_after_rd, i_clk, i_rst_n, (r_state == B_CALC) |-> ($past(r_state) == B_RD || $past(r_state) == B_CALC), "conversion without a memory read")

endmodule

### rtl/nv21_to_rgb_converter.sv
// top level of the nv21 to rgb888 converter
`timescale 1ns / 1ps
// v bytes are taken whenever the front runs; a u byte is taken while the block queue has room
// the back unit works a 2x2 block as pop, coefficient multiply, then one luma read per pixel
// after pop, multiply and read, a block's pixels leave one per cycle while m_axis_tready is high
// a luma byte waits until the queue and the back unit are empty, so queued blocks read stable luma
// after reset and each config write the front resyncs: set, load, then a divide step per position bit
// reset clears control state and sets 640x480; the luma memory is not cleared

module nv21_to_rgb_converter
    import nvrgb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // data_byte
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // frame_start
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], packed_rgb[47:24], pixel_index[67:48], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // last_of_block
    output logic                   m_axis_tlast
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CRW   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int BW    = 16 + WW + CRW;

    t_back_stat    stat;
    logic          blk_push;
    logic [BW-1:0] blk_wdata;
    logic          blk_full;
    logic          blk_pop;
    logic [BW-1:0] blk_rdata;
    logic          blk_empty;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [WW-1:0] width;
    logic          back_idle;

    assign stat.fifo_full = blk_full;
    assign stat.back_idle = blk_empty && back_idle;

    nvrgb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_tvalid      (s_axis_tvalid),
        .o_tready      (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_frame_start (s_axis_tuser[0]),
        .i_stat        (stat),
        .o_blk_push    (blk_push),
        .o_blk_data    (blk_wdata),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_width       (width)
    );

    nvrgb_fifo #(
        .DW    (BW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (blk_push),
        .i_data  (blk_wdata),
        .o_full  (blk_full),
        .i_pop   (blk_pop),
        .o_data  (blk_rdata),
        .o_empty (blk_empty)
    );

    nvrgb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk_data  (blk_rdata),
        .i_blk_empty (blk_empty),
        .o_blk_pop   (blk_pop),
        .i_width     (width),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_idle      (back_idle),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

endmodule

### dv/nvrgb_pixel_checker.sv
// pixel checker for the nv21 to rgb converter: predicts pixels from the byte stream and compares
`timescale 1ns / 1ps

module nvrgb_pixel_checker
    import nvrgb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // data_byte
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // frame_start
    input  logic [0:0]             s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], packed_rgb[47:24], pixel_index[67:48], zero pad
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // last_of_block
    input  logic                   m_axis_tlast,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_pixels_seen
);

    // q16 conversion coefficients
    localparam longint RV_Q16 = 89831;
    localparam longint GV_Q16 = 45744;
    localparam longint GU_Q16 = 22127;
    localparam longint BU_Q16 = 113538;

    typedef struct packed {
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [23:0]          rgb;
        logic [PIX_IDX_W-1:0] index;
        logic                 last;
    } t_pixel;

    t_pixel           expected_pixels[$];
    logic [7:0]       luma_mem [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
    int unsigned      frame_pos = 0;
    logic [7:0]       v_hold = '0;
    logic [CFG_W-1:0] width_reg = CFG_W'(RESET_WIDTH);
    logic [CFG_W-1:0] height_reg = CFG_W'(RESET_HEIGHT);
    int               failures = 0;
    int               pixels_seen = 0;

    // lowest bit dropped, then held inside 2..limit
    function automatic int unsigned usable_dim(logic [CFG_W-1:0] raw, int unsigned limit);
        int unsigned d;
        d = 32'({raw[CFG_W-1:1], 1'b0});
        if (d < 2) d = 2;
        if (d > (limit & 32'hFFFF_FFFE)) d = limit & 32'hFFFF_FFFE;
        return d;
    endfunction

    function automatic logic [7:0] sat_channel(longint acc);
        longint v;
        if (acc < 0) return 8'd0;
        v = acc >>> 16;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    // a u byte yields the four pixels of its 2x2 block in raster order
    function automatic void queue_block(int unsigned k, int unsigned w, logic [7:0] u_byte);
        longint      du, dv, yq;
        int unsigned crow, ccol, idx;
        t_pixel      px;
        du = longint'(u_byte);
        du = du - 128;
        dv = longint'(v_hold);
        dv = dv - 128;
        crow = k / w;
        ccol = (k % w) & 32'hFFFF_FFFE;
        for (int n = 0; n < 4; n++) begin
            idx = (2 * crow + n / 2) * w + ccol + n % 2;
            yq = longint'(luma_mem[idx]);
            yq = yq * 65536;
            px.red   = sat_channel(yq + RV_Q16 * dv);
            px.green = sat_channel(yq - GV_Q16 * dv - GU_Q16 * du);
            px.blue  = sat_channel(yq + BU_Q16 * du);
            px.rgb   = {px.red, px.green, px.blue};
            px.index = idx[PIX_IDX_W-1:0];
            px.last  = (n == 3);
            expected_pixels.insert(expected_pixels.size(), px);
        end
    endfunction

    function automatic void take_byte(logic [7:0] data_byte, logic frame_start);
        int unsigned w, h, wh, total, pos, k;
        w = usable_dim(width_reg, DEF_MAX_WIDTH);
        h = usable_dim(height_reg, DEF_MAX_HEIGHT);
        wh = w * h;
        total = wh + wh / 2;
        pos = frame_start ? 0 : frame_pos;
        if (pos >= total) begin
            // past the end of the frame: parked until the next frame start
            frame_pos = total;
            return;
        end
        frame_pos = pos + 1;
        if (pos < wh) begin
            luma_mem[pos] = data_byte;
            return;
        end
        k = pos - wh;
        if (k[0] == 1'b0) v_hold = data_byte;
        else queue_block(k, w, data_byte);
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            expected_pixels.delete();
            frame_pos  = 0;
            v_hold     = '0;
            width_reg  = CFG_W'(RESET_WIDTH);
            height_reg = CFG_W'(RESET_HEIGHT);
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    $error("pixel transaction with nothing expected: tdata %h", m_axis_tdata);
                    failures++;
                end else begin
                    want = expected_pixels.pop_front();
                    compare_field("red", want.red, m_axis_tdata[7:0]);
                    compare_field("green", want.green, m_axis_tdata[15:8]);
                    compare_field("blue", want.blue, m_axis_tdata[23:16]);
                    compare_field("packed_rgb", want.rgb, m_axis_tdata[47:24]);
                    compare_field("pixel_index", want.index, m_axis_tdata[67:48]);
                    compare_field("pad", 0, m_axis_tdata[OUT_TDATA_W-1:68]);
                    compare_field("last_of_block", want.last, m_axis_tlast);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH: width_reg = i_cfg_data;
                    REG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tuser[0]);
        end
        o_fail_count  <= failures;
        o_pending     <= expected_pixels.size();
        o_pixels_seen <= pixels_seen;
    end

endmodule

### dv/testbench.sv
// testbench top for the nv21 to rgb converter: byte stream stimulus, config writes and verdict
`timescale 1ns / 1ps

module testbench;
    import nvrgb_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BYTES  = 280;
    localparam int EDGE_LUMA     = 24;
    localparam int TIMEOUT_NS    = 20_000_000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    int          fail_count;
    int          pending;
    int          pixels_seen;
    bit          idle_on = 1'b1;
    int          stall_left = 0;
    int unsigned cur_w = RESET_WIDTH;
    int unsigned cur_h = RESET_HEIGHT;
    int          bytes_sent = 0;
    int          frames_started = 0;

    nv21_to_rgb_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    nvrgb_pixel_checker pixel_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_pixels_seen (pixels_seen)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver back-pressure in random bursts, started only while idle_on is set
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && i_rst_n && $urandom_range(0, 6) == 0) begin
            stall_left    <= int'($urandom_range(0, 4));
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] data_byte, input logic frame_start);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data_byte;
        s_axis_tuser  <= frame_start;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        if (frame_start) frames_started++;
    endtask

    // stop the stream, let every expected pixel come out, then let the back end go quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        int unsigned d;
        wait_idle();
        d = 32'({value[CFG_W-1:1], 1'b0});
        if (d < 2) d = 2;
        if (idx == REG_FRAME_WIDTH) cur_w = (d > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : d;
        else cur_h = (d > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : d;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // luma bytes first, then v,u chroma pairs, then bytes past the end of the frame
    task automatic send_frame(input int unsigned luma_n, input int unsigned chroma_n,
                              input int unsigned extra_n);
        logic [7:0] pick;
        for (int unsigned i = 0; i < luma_n + chroma_n + extra_n; i++) begin
            case ($urandom_range(0, 7))
                0: pick = 8'd0;
                1: pick = 8'd255;
                default: pick = 8'($urandom);
            endcase
            push_byte(pick, i == 0);
        end
    endtask

    initial begin
        int unsigned useful, wh, mode, luma_n, chroma_n, extra_n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: saturating colors at 2x2
        write_reg(REG_FRAME_WIDTH, 11'd2);
        write_reg(REG_FRAME_HEIGHT, 11'd2);
        push_byte(8'd255, 1'b1);
        push_byte(8'd255, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'd255, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'd0, 1'b1);
        push_byte(8'd255, 1'b0);
        push_byte(8'd128, 1'b0);
        push_byte(8'd16, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'd255, 1'b0);
        // width grows from 2 to 4 while the luma plane is half written
        push_byte(8'd1, 1'b1);
        push_byte(8'd254, 1'b0);
        push_byte(8'd127, 1'b0);
        push_byte(8'd128, 1'b0);
        write_reg(REG_FRAME_WIDTH, 11'd4);
        push_byte(8'd64, 1'b0);
        push_byte(8'd192, 1'b0);
        push_byte(8'd8, 1'b0);
        push_byte(8'd247, 1'b0);
        push_byte(8'd128, 1'b0);
        push_byte(8'd128, 1'b0);
        push_byte(8'd200, 1'b0);
        push_byte(8'd60, 1'b0);
        push_byte(8'd17, 1'b0);
        push_byte(8'd99, 1'b0);

        // extreme sizes reached through odd and out-of-range writes, luma only
        write_reg(REG_FRAME_WIDTH, 11'd2047);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        send_frame(EDGE_LUMA, 0, 0);
        write_reg(REG_FRAME_WIDTH, 11'd0);
        write_reg(REG_FRAME_HEIGHT, 11'd1025);
        send_frame(EDGE_LUMA, 0, 0);

        // random small frames, mostly complete, some cut short or overrun
        write_reg(REG_FRAME_WIDTH, 11'($urandom_range(0, 9)));
        write_reg(REG_FRAME_HEIGHT, 11'($urandom_range(0, 5)));
        useful = 0;
        while (useful < RANDOM_BYTES) begin
            idle_on = (useful > RANDOM_BYTES * 4 / 5) ? 1'b0 : ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 2) == 0) write_reg(REG_FRAME_WIDTH, 11'($urandom_range(0, 9)));
            if ($urandom_range(0, 2) == 0) write_reg(REG_FRAME_HEIGHT, 11'($urandom_range(0, 5)));
            wh = cur_w * cur_h;
            mode = $urandom_range(0, 19);
            luma_n = wh;
            chroma_n = wh / 2;
            extra_n = 0;
            if (mode >= 19) extra_n = $urandom_range(1, 4);
            else if (mode >= 17) begin
                luma_n = $urandom_range(1, wh - 1);
                chroma_n = 0;
            end else if (mode >= 14) chroma_n = $urandom_range(1, wh / 2 - 1);
            useful += luma_n + chroma_n;
            send_frame(luma_n, chroma_n, extra_n);
        end

        idle_on = 1'b0;
        wait_idle();
        $display("run covered %0d frame starts, %0d bytes and %0d checked pixels",
                 frames_started, bytes_sent, pixels_seen);
        $display("sizes: 2x2, mid-frame width change, clamped 1024x2 and 2x1024 luma, random up to 8x4");
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
